### hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LZ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define LZ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that also holds during reset.
`define LZ_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/lz78ttd_pkg.sv
// Shared types and constants of the LZ78 text token decoder.
// No dependencies; used by the front, queue and back modules.
`timescale 1ns / 1ps
`default_nettype none

package lz78ttd_pkg;

  localparam logic [7:0] DIGIT_LOW  = 8'h30;
  localparam logic [7:0] DIGIT_HIGH = 8'h39;
  localparam int         RADIX      = 10;
  localparam int         QUEUE_DEPTH = 2;

  // Queue status seen by both sides of the token queue.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Back-end sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LEN   = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_EREAD = 6'b001000,
    ST_EPUSH = 6'b010000,
    ST_LIT   = 6'b100000
  } back_state_e;

endpackage

`default_nettype wire

### hdl/lz78_text_token_decoder.sv
// LZ78 text token decoder, one item in and one decoded byte out per handshake.
// Input side: in_valid_i / in_stall_o with in_byte_i and start_of_stream_i.
// Output side: out_valid_o / out_stall_i with out_byte_o, last_of_phrase_o and
// bad_reference_o. An item moves at a clock edge where valid is high and stall low.
// Digit bytes are taken one per cycle while the queue has room and produce nothing;
// a literal byte is queued as a token for the back end; the queue holds two tokens.
// Per token with a phrase of L bytes the back end takes the token, reads the entry
// length, walks the prefix chain (one dictionary read per link), replays the buffer
// with a read and a push per phrase byte, and then emits the literal. Index-zero,
// undefined and overflowed tokens go straight to the literal, a token whose phrase
// would run too long goes to it after the length read. The first byte leaves only
// once the whole prefix chain has been walked.
// Reset empties the queue, the output register and the dictionary count at once;
// no clearing pass is needed. start_of_stream_i restarts the dictionary.
// A stalled receiver holds the output byte; the back end then waits, the queue
// fills and in_stall_o rises.
// Depends on lz78ttd_pkg, lz78ttd_front, lz78ttd_fifo and lz78ttd_back.
`timescale 1ns / 1ps
`default_nettype none

module lz78_text_token_decoder import lz78ttd_pkg::*; #(
  parameter int DICT_ENTRIES = 512,
  parameter int MAX_PHRASE   = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       start_of_stream_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_phrase_o,
  output logic            bad_reference_o
);

  // index width covers entries 0 .. DICT_ENTRIES-1
  localparam int IDXW = $clog2(DICT_ENTRIES);
  // token: clear flag, overflow flag, index, literal byte
  localparam int TOKW = 2 + IDXW + 8;

  logic            push, pop;
  logic [TOKW-1:0] push_data, pop_data;
  queue_stat_t     q_stat;

  // classify bytes and build tokens
  lz78ttd_front #(
    .DICT_ENTRIES (DICT_ENTRIES),
    .IDXW         (IDXW),
    .TOKW         (TOKW)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_byte_i         (in_byte_i),
    .start_of_stream_i (start_of_stream_i),
    .q_stat_i          (q_stat),
    .push_o            (push),
    .push_data_o       (push_data)
  );

  // decouple front and back
  lz78ttd_fifo #(
    .WIDTH (TOKW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // walk the dictionary and emit the phrase and literal
  lz78ttd_back #(
    .DICT_ENTRIES (DICT_ENTRIES),
    .MAX_PHRASE   (MAX_PHRASE),
    .IDXW         (IDXW),
    .TOKW         (TOKW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_stat_i         (q_stat),
    .tok_i            (pop_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_of_phrase_o (last_of_phrase_o),
    .bad_reference_o  (bad_reference_o)
  );

endmodule

`default_nettype wire

### hdl/lz78ttd_fifo.sv
// Short token queue between the front and back of the decoder.
// Depends on lz78ttd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lz78ttd_fifo import lz78ttd_pkg::*; #(
  parameter int WIDTH = 19
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o,
  output queue_stat_t           stat_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (fill_q == CW'(QUEUE_DEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = CW'(fill_q + 1'b1);
      2'b01:   fill_d = CW'(fill_q - 1'b1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hdl/lz78ttd_front.sv
// Front end: accepts bytes, builds the decimal index, queues one token per literal.
// Depends on lz78ttd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lz78ttd_front import lz78ttd_pkg::*; #(
  parameter int DICT_ENTRIES = 512,
  parameter int IDXW         = 9,
  parameter int TOKW         = 19
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            start_of_stream_i,
  input  queue_stat_t          q_stat_i,
  output logic                 push_o,
  output logic [TOKW-1:0]      push_data_o
);

  localparam int ACCW = IDXW + 4;

  logic [IDXW-1:0] acc_q, acc_d, acc_base;
  logic            ovf_q, ovf_d, ovf_base;
  logic            clr_q, clr_d;
  logic [ACCW-1:0] acc_next;
  logic            is_digit, accept, too_big;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign is_digit   = (in_byte_i >= DIGIT_LOW) && (in_byte_i <= DIGIT_HIGH);
  assign acc_base   = start_of_stream_i ? '0 : acc_q;
  assign ovf_base   = start_of_stream_i ? 1'b0 : ovf_q;
  assign acc_next   = ACCW'(acc_base) * ACCW'(RADIX) + ACCW'(in_byte_i - DIGIT_LOW);
  assign too_big    = acc_next > ACCW'(DICT_ENTRIES - 1);

  // token layout: clear, overflow, index, literal
  assign push_o      = accept && !is_digit;
  assign push_data_o = {clr_q | start_of_stream_i, ovf_base, acc_base, in_byte_i};

  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    clr_d = clr_q;
    if (accept) begin
      if (is_digit) begin
        // hold the accumulator once it has overflowed
        acc_d = (too_big || ovf_base) ? acc_base : acc_next[IDXW-1:0];
        ovf_d = ovf_base | too_big;
        clr_d = clr_q | start_of_stream_i;
      end else begin
        acc_d = '0;
        ovf_d = 1'b0;
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
      clr_q <= clr_d;
    end
  end

endmodule

`default_nettype wire

### hdl/lz78ttd_back.sv
// Back end: dictionary, prefix chain walk, phrase buffer and output register.
// Depends on lz78ttd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lz78ttd_back import lz78ttd_pkg::*; #(
  parameter int DICT_ENTRIES = 512,
  parameter int MAX_PHRASE   = 64,
  parameter int IDXW         = 9,
  parameter int TOKW         = 19
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  queue_stat_t          q_stat_i,
  input  wire logic [TOKW-1:0] tok_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_of_phrase_o,
  output logic                 bad_reference_o
);

  localparam int LENW = $clog2(MAX_PHRASE + 1);
  localparam int POSW = $clog2(MAX_PHRASE);
  localparam logic [IDXW-1:0] MAX_IDX = IDXW'(DICT_ENTRIES - 1);

  // dictionary and phrase buffer
  logic [IDXW-1:0] pre_mem [DICT_ENTRIES];
  logic [7:0]      sym_mem [DICT_ENTRIES];
  logic [LENW-1:0] len_mem [DICT_ENTRIES];
  logic [7:0]      buf_mem [MAX_PHRASE];

  logic [IDXW-1:0] pre_rd_q;
  logic [7:0]      sym_rd_q;
  logic [LENW-1:0] len_rd_q;
  logic [7:0]      buf_rd_q;

  back_state_e     state_q, state_d;
  logic [IDXW-1:0] idx_q, idx_d;
  logic [7:0]      lit_q, lit_d;
  logic            bad_q, bad_d;
  logic [LENW-1:0] len_q, len_d;
  logic [LENW-1:0] pos_q, pos_d;
  logic [LENW-1:0] rp_q, rp_d;
  logic [IDXW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_last_q, out_last_d;
  logic            out_bad_q, out_bad_d;
  logic            load;

  logic            tok_clr, tok_ovf;
  logic [IDXW-1:0] tok_idx;
  logic [7:0]      tok_lit;
  logic [IDXW-1:0] cnt_eff;
  logic [IDXW-1:0] rd_addr;
  logic            slot_free;
  logic            buf_we;
  logic [POSW-1:0] buf_waddr;
  logic [LENW-1:0] pos_m1;
  logic            dict_we;
  logic [IDXW-1:0] dict_waddr, dict_wpre;
  logic [LENW-1:0] dict_wlen;

  assign {tok_clr, tok_ovf, tok_idx, tok_lit} = tok_i;
  assign cnt_eff   = tok_clr ? '0 : cnt_q;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign pos_m1    = LENW'(pos_q - 1'b1);
  assign buf_waddr = pos_m1[POSW-1:0];
  assign pop_o     = (state_q == ST_IDLE) && !q_stat_i.empty;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    lit_d      = lit_q;
    bad_d      = bad_q;
    len_d      = len_q;
    pos_d      = pos_q;
    rp_d       = rp_q;
    cnt_d      = cnt_q;
    rd_addr    = idx_q;
    load       = 1'b0;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_bad_d  = out_bad_q;
    buf_we     = 1'b0;
    dict_we    = 1'b0;
    dict_waddr = IDXW'(cnt_q + 1'b1);
    dict_wpre  = bad_q ? '0 : idx_q;
    dict_wlen  = bad_q ? LENW'(1) : LENW'(len_q + 1'b1);
    case (state_q)
      ST_IDLE: begin
        rd_addr = tok_idx;
        if (!q_stat_i.empty) begin
          cnt_d = cnt_eff;
          idx_d = tok_idx;
          lit_d = tok_lit;
          len_d = '0;
          if (tok_ovf || (tok_idx > cnt_eff)) begin
            bad_d   = 1'b1;
            state_d = ST_LIT;
          end else if (tok_idx == '0) begin
            bad_d   = 1'b0;
            state_d = ST_LIT;
          end else begin
            bad_d   = 1'b0;
            state_d = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        // re-read the same entry so its symbol is ready for the walk
        rd_addr = idx_q;
        if (({1'b0, len_rd_q} + (LENW + 1)'(1)) > (LENW + 1)'(MAX_PHRASE)) begin
          bad_d   = 1'b1;
          len_d   = '0;
          state_d = ST_LIT;
        end else begin
          len_d   = len_rd_q;
          pos_d   = len_rd_q;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        // store symbols last to first, follow the prefix link
        rd_addr = pre_rd_q;
        buf_we  = 1'b1;
        pos_d   = pos_m1;
        if (pos_q == LENW'(1)) begin
          rp_d    = '0;
          state_d = ST_EREAD;
        end
      end
      ST_EREAD: begin
        state_d = ST_EPUSH;
      end
      ST_EPUSH: begin
        if (slot_free) begin
          load       = 1'b1;
          out_byte_d = buf_rd_q;
          out_last_d = 1'b0;
          out_bad_d  = 1'b0;
          rp_d       = LENW'(rp_q + 1'b1);
          state_d    = (LENW'(rp_q + 1'b1) == len_q) ? ST_LIT : ST_EREAD;
        end
      end
      ST_LIT: begin
        if (slot_free) begin
          load       = 1'b1;
          out_byte_d = lit_q;
          out_last_d = 1'b1;
          out_bad_d  = bad_q;
          state_d    = ST_IDLE;
          if (cnt_q != MAX_IDX) begin
            dict_we = 1'b1;
            cnt_d   = IDXW'(cnt_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    lit_q      <= lit_d;
    bad_q      <= bad_d;
    len_q      <= len_d;
    pos_q      <= pos_d;
    rp_q       <= rp_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  always_ff @(posedge clk_i) begin
    pre_rd_q <= pre_mem[rd_addr];
    sym_rd_q <= sym_mem[rd_addr];
    len_rd_q <= len_mem[rd_addr];
    if (dict_we) begin
      pre_mem[dict_waddr] <= dict_wpre;
      sym_mem[dict_waddr] <= lit_q;
      len_mem[dict_waddr] <= dict_wlen;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_rd_q <= buf_mem[rp_q[POSW-1:0]];
    if (buf_we) begin
      buf_mem[buf_waddr] <= sym_rd_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign last_of_phrase_o = out_last_q;
  assign bad_reference_o  = out_bad_q;

endmodule

`default_nettype wire

### hdl/lz78ttd_checker.sv
// Port-level checker for the LZ78 text token decoder, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lz78ttd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] in_byte_i,
  input wire logic       start_of_stream_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_of_phrase_o,
  input wire logic       bad_reference_o
);

  `LZ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "output item dropped while stalled")
  `LZ_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_byte_o) && $stable(last_of_phrase_o) && $stable(bad_reference_o), "stalled output item changed")
  `LZ_ASSERT_NOW(a_bad_is_last, clk_i, rst_ni, out_valid_o && bad_reference_o, last_of_phrase_o, "bad token emitted more than its literal")
  `LZ_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni, !out_valid_o, "output valid during reset")

endmodule

bind lz78_text_token_decoder lz78ttd_checker u_checker (.*);

`default_nettype wire

### test/tb.sv
// Self-checking testbench for lz78_text_token_decoder: a directed token table, then random
// token streams that grow prefix chains, every output byte checked against a table row or a model.
// Depends on lz78ttd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;
  import lz78ttd_pkg::*;

  localparam int DICT_ENTRIES = 512;
  localparam int MAX_PHRASE   = 64;
  localparam int IDLE_LIMIT   = 2000;                // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 3 * MAX_PHRASE + 60; // longest token the back end can be busy with
  localparam int RANDOM_ITEMS = 107;
  localparam int N_DIRECTED   = 23;
  localparam int HOLD_AFTER   = 25;                  // results seen before the long output hold
  localparam int HOLD_CYCLES  = 300;

  // One decoded byte as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } out_item_t;

  // One input item; typed rows carry the single result that they must produce.
  typedef struct packed {
    logic [7:0] data;
    logic       sos;
    logic       typed;
    logic [7:0] want_data;
    logic       want_last;
    logic       want_bad;
  } stim_row_t;

  logic       clk_i             = 1'b0;
  logic       rst_ni;
  logic       in_valid_i        = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i         = 8'h00;
  logic       start_of_stream_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i       = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_of_phrase_o;
  logic       bad_reference_o;

  // Decoder model state.
  logic [8:0] dict_prefix [DICT_ENTRIES];
  logic [7:0] dict_symbol [DICT_ENTRIES];
  logic [6:0] dict_length [DICT_ENTRIES];
  logic [8:0] dict_count     = '0;
  logic [9:0] index_accum    = '0;
  logic       index_overflow = 1'b0;
  out_item_t  decoded_run [MAX_PHRASE];
  out_item_t  expected_bytes [$];

  int   items_sent     = 0;
  int   results_seen   = 0;
  int   fail_count     = 0;
  int   quiet_cycles   = 0;
  logic send_steady    = 1'b0;
  logic sink_steady    = 1'b0;
  logic long_hold_done = 1'b0;

  // Directed tokens: fresh dictionary, chained phrases, undefined and overflowing indexes,
  // leading zeros, byte extremes either side of the digit range, and a restart mid-stream.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{"A",   1'b1, 1'b1, "A",   1'b1, 1'b0},  // index zero on a cleared dictionary
    '{"1",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"B",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // A then B
    '{"2",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"C",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // A B then C
    '{"9",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"x",   1'b0, 1'b1, "x",   1'b1, 1'b1},  // entry 9 not defined yet
    '{"9",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"9",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"9",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"y",   1'b0, 1'b1, "y",   1'b1, 1'b1},  // 999 runs past the table
    '{"0",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"0",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"3",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"z",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // leading zeros, phrase A B C
    '{8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0},
    '{"/",   1'b0, 1'b1, "/",   1'b1, 1'b0},  // just below the digits
    '{":",   1'b0, 1'b1, ":",   1'b1, 1'b0},  // just above the digits
    '{"3",   1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // restart on a digit
    '{"q",   1'b0, 1'b1, "q",   1'b1, 1'b1},  // entry 3 gone after the restart
    '{"1",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{"!",   1'b0, 1'b0, 8'h00, 1'b0, 1'b0}   // q then !
  };

  lz78_text_token_decoder #(
    .DICT_ENTRIES(DICT_ENTRIES),
    .MAX_PHRASE  (MAX_PHRASE)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .start_of_stream_i(start_of_stream_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .last_of_phrase_o (last_of_phrase_o),
    .bad_reference_o  (bad_reference_o)
  );

  always #10 clk_i = ~clk_i;

  // Append an entry unless the dictionary is full.
  function automatic void dict_append(input int prefix, input logic [7:0] sym, input int len);
    if (dict_count < DICT_ENTRIES - 1) begin
      dict_count              = dict_count + 9'd1;
      dict_prefix[dict_count] = prefix[8:0];
      dict_symbol[dict_count] = sym;
      dict_length[dict_count] = len[6:0];
    end
  endfunction

  // Decode one input byte; fill decoded_run and return how many bytes it yields.
  function automatic int lz78_decode_byte(input logic [7:0] data, input logic sos);
    int         next_index;
    int         len;
    int         link;
    int         pos;
    logic [7:0] phrase [MAX_PHRASE];
    if (sos) begin
      dict_count     = '0;
      index_accum    = '0;
      index_overflow = 1'b0;
    end
    if (data >= DIGIT_LOW && data <= DIGIT_HIGH) begin
      next_index = int'(index_accum) * RADIX + int'(data - DIGIT_LOW);
      if (next_index > DICT_ENTRIES - 1) index_overflow = 1'b1;
      else if (!index_overflow) index_accum = next_index[9:0];
      return 0;
    end
    len = 0;
    if (!index_overflow && index_accum <= dict_count && index_accum != 0)
      len = dict_length[index_accum[8:0]];
    // Bad token: literal alone, still numbered as an entry.
    if (index_overflow || index_accum > dict_count || len + 1 > MAX_PHRASE) begin
      decoded_run[0].data = data;
      decoded_run[0].last = 1'b1;
      decoded_run[0].bad  = 1'b1;
      dict_append(0, data, 1);
      index_accum    = '0;
      index_overflow = 1'b0;
      return 1;
    end
    // Walk the prefix chain from the tail back to the head.
    link = index_accum;
    for (pos = len - 1; pos >= 0; pos--) begin
      phrase[pos] = dict_symbol[link];
      link        = dict_prefix[link];
    end
    for (pos = 0; pos < len; pos++) begin
      decoded_run[pos].data = phrase[pos];
      decoded_run[pos].last = 1'b0;
      decoded_run[pos].bad  = 1'b0;
    end
    decoded_run[len].data = data;
    decoded_run[len].last = 1'b1;
    decoded_run[len].bad  = 1'b0;
    dict_append(index_accum, data, len + 1);
    index_accum    = '0;
    index_overflow = 1'b0;
    return len + 1;
  endfunction

  function automatic logic [7:0] rand_literal();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v >= DIGIT_LOW && v <= DIGIT_HIGH);
    return v;
  endfunction

  // Offer one item after a random gap, hold it until taken, then queue what it decodes to.
  // Entered and left on a falling edge.
  task automatic send_item(input stim_row_t row);
    int        gap;
    int        produced;
    out_item_t want;
    if ($urandom_range(0, 15) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_byte_i         <= row.data;
    start_of_stream_i <= row.sos;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    produced = lz78_decode_byte(row.data, row.sos);
    if (row.typed) begin
      want.data = row.want_data;
      want.last = row.want_last;
      want.bad  = row.want_bad;
      expected_bytes.push_back(want);
    end else begin
      for (int k = 0; k < produced; k++) expected_bytes.push_back(decoded_run[k]);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // Send a token: optional leading zeros, the decimal index (none for zero), then the literal.
  task automatic send_token(input int idx, input int zeros, input logic [7:0] lit,
                            input logic sos);
    string     digits;
    stim_row_t row;
    logic      first;
    first = sos;
    row   = '0;
    if (idx > 0) digits = $sformatf("%0d", idx);
    else digits = "";
    for (int k = 0; k < zeros + digits.len(); k++) begin
      if (k < zeros) row.data = DIGIT_LOW;
      else row.data = digits[k - zeros];
      row.sos = first;
      first   = 1'b0;
      send_item(row);
    end
    row.data = lit;
    row.sos  = first;
    send_item(row);
  endtask

  // Mostly well-formed tokens, leaning on recent entries so chains grow; some noise bytes,
  // undefined and overflowing indexes, and the odd restart.
  task automatic random_token(input logic allow_restart);
    int        kind;
    int        cnt;
    int        idx;
    int        zeros;
    logic      sos;
    stim_row_t row;
    sos   = allow_restart && ($urandom_range(0, 39) == 0);
    cnt   = sos ? 0 : int'(dict_count);
    kind  = $urandom_range(0, 99);
    zeros = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
    if (kind < 10) begin
      row      = '0;
      row.data = 8'($urandom_range(0, 255));
      row.sos  = sos;
      send_item(row);
    end else if (kind < 18 && cnt < DICT_ENTRIES - 1) begin
      send_token($urandom_range(cnt + 1, DICT_ENTRIES - 1), zeros, rand_literal(), sos);
    end else if (kind < 24) begin
      send_token($urandom_range(DICT_ENTRIES, 99999), zeros, rand_literal(), sos);
    end else begin
      case ($urandom_range(0, 2))
        0: idx = 0;
        1: idx = (cnt > 3) ? cnt - $urandom_range(0, 3) : cnt;
        default: idx = $urandom_range(0, cnt);
      endcase
      send_token(idx, zeros, rand_literal(), sos);
    end
  endtask

  // Drop valid and hold until every queued byte has come out. Ends on a falling edge.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < N_DIRECTED; r++) send_item(directed_rows[r]);

    // Pause the sender until the output side has caught up.
    wait_for_drain();

    while (items_sent < N_DIRECTED + RANDOM_ITEMS) random_token(1'b1);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_bytes.size() == 0) begin
      $display("[lz78_text_token_decoder] OK");
    end else begin
      $display("[lz78_text_token_decoder] ERROR");
    end
    $finish;
  end

  // Output side: random stall before each byte, steady stretches, and one long hold
  // while the sender keeps offering so that the block backs up into its input.
  initial begin : result_sink
    int        gap;
    out_item_t got;
    out_item_t want;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
      gap = sink_steady ? 0 : $urandom_range(0, 3);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        gap            = HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.data = out_byte_o;
      got.last = last_of_phrase_o;
      got.bad  = bad_reference_o;
      results_seen++;
      if (expected_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected output: byte %02h last %b bad %b", got.data, got.last, got.bad);
      end else begin
        want = expected_bytes.pop_front();
        if (got.data !== want.data || got.last !== want.last || got.bad !== want.bad) begin
          fail_count++;
          if (fail_count <= 10)
            $display("output %0d: expected byte %02h last %b bad %b, got byte %02h last %b bad %b",
                     results_seen, want.data, want.last, want.bad,
                     got.data, got.last, got.bad);
        end
      end
      @(negedge clk_i);
    end
  end

  // Watchdog: give up when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[lz78_text_token_decoder] ERROR");
        $finish;
      end
    end
  end

endmodule
